>>> rtl/qnlerp_pkg.sv
package qnlerp_pkg;

  // blend weight format: unsigned Q1.15
  localparam int unsigned BLEND_W = 16;
  localparam logic [BLEND_W-1:0] BLEND_ONE = 16'h8000;

  // aligned magnitude, its square, the squared length and its root
  localparam int unsigned R_W    = 30;
  localparam int unsigned SQ_W   = 2 * R_W;
  localparam int unsigned Q_W    = SQ_W + 2;
  localparam int unsigned ROOT_W = Q_W / 2;
  localparam int unsigned RM_W   = ROOT_W + 2;

  // sideband that travels with an item through the back half of the pipe
  typedef struct packed {
    logic       vld;
    logic       zero;
    logic [3:0] neg;
  } side_t;

endpackage

>>> rtl/quaternion_nlerp.sv
// Normalized linear blend of two quaternions (nlerp), fully pipelined.
//
// Input: raise start_i with both quaternions (signed Q2.14 at the default
// width) and blend_i (unsigned Q1.15, 0x8000 is one, larger values clamp).
// An item is taken at each rising edge with start_i high and busy_o low;
// busy_o is always low, so a new item may enter on every cycle.
//
// Output: done_o is high for exactly one cycle with out_x_o..out_w_o and
// degenerate_o, which are valid only in that cycle. The receiver cannot
// stall the block. A zero-length blend gives all-zero components and
// degenerate_o high.
//
// Throughput is one item per cycle. The delay to done_o comes from the 31
// one-bit steps of the square root of the squared length and the
// COMPONENT_BITS - 1 one-bit steps of the divider that scales each
// component by that length.
//
// Reset clears all valid bits, so items in flight at reset are dropped.
module quaternion_nlerp
  import qnlerp_pkg::*;
#(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [COMPONENT_BITS-1:0] first_x_i,
  input  logic signed [COMPONENT_BITS-1:0] first_y_i,
  input  logic signed [COMPONENT_BITS-1:0] first_z_i,
  input  logic signed [COMPONENT_BITS-1:0] first_w_i,
  input  logic signed [COMPONENT_BITS-1:0] second_x_i,
  input  logic signed [COMPONENT_BITS-1:0] second_y_i,
  input  logic signed [COMPONENT_BITS-1:0] second_z_i,
  input  logic signed [COMPONENT_BITS-1:0] second_w_i,
  input  logic        [BLEND_W-1:0]        blend_i,
  output logic                             done_o,
  output logic signed [COMPONENT_BITS-1:0] out_x_o,
  output logic signed [COMPONENT_BITS-1:0] out_y_o,
  output logic signed [COMPONENT_BITS-1:0] out_z_o,
  output logic signed [COMPONENT_BITS-1:0] out_w_o,
  output logic                             degenerate_o
);

  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned FB = CB - 2;          // fraction bits
  localparam int unsigned PW = 2 * CB;          // component product
  localparam int unsigned DW = PW + 2;          // dot product sum
  localparam int unsigned WW = BLEND_W + 1;     // weight as signed
  localparam int unsigned XW = CB + WW;         // weighted component
  localparam int unsigned VW = CB + BLEND_W;    // blended component
  localparam int unsigned MW = VW - 1;          // blended magnitude
  localparam int unsigned EW = $clog2(MW + 1);  // bit length of magnitude
  localparam int unsigned SW = MW + R_W;        // alignment window
  localparam int unsigned QB = FB + 1;          // quotient bits
  localparam int unsigned NW = R_W + QB;        // dividend
  localparam logic [QB-1:0] MAG_ONE = {1'b1, {FB{1'b0}}};

  // the pipeline never blocks
  assign busy_o = 1'b0;

  logic signed [CB-1:0] a [4];
  logic signed [CB-1:0] b [4];

  assign a[0] = first_x_i;
  assign a[1] = first_y_i;
  assign a[2] = first_z_i;
  assign a[3] = first_w_i;
  assign b[0] = second_x_i;
  assign b[1] = second_y_i;
  assign b[2] = second_z_i;
  assign b[3] = second_w_i;

  // ---------------------------------------------------------------------
  // stage 1: clamp the weight, all products
  // ---------------------------------------------------------------------
  logic [BLEND_W-1:0] w1, w0;
  logic signed [XW-1:0] aw_d [4];
  logic signed [XW-1:0] bw_d [4];

  assign w1 = (blend_i > BLEND_ONE) ? BLEND_ONE : blend_i;
  assign w0 = BLEND_ONE - w1;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      aw_d[i] = XW'(a[i]) * XW'($signed({1'b0, w0}));
      bw_d[i] = XW'(b[i]) * XW'($signed({1'b0, w1}));
    end
  end

  logic                 s1_vld_q;
  logic signed [PW-1:0] s1_ab_q [4];
  logic signed [VW-1:0] s1_pa_q [4];
  logic signed [VW-1:0] s1_pb_q [4];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      s1_ab_q[i] <= PW'(a[i]) * PW'(b[i]);
      s1_pa_q[i] <= aw_d[i][VW-1:0];
      s1_pb_q[i] <= bw_d[i][VW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: dot product sign, both blend candidates
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] dot_d;

  always_comb begin
    dot_d = '0;
    for (int i = 0; i < 4; i++) begin
      dot_d = dot_d + DW'(s1_ab_q[i]);
    end
  end

  logic                 s2_vld_q;
  logic                 s2_neg_q;
  logic signed [VW-1:0] s2_sum_q [4];
  logic signed [VW-1:0] s2_dif_q [4];

  always_ff @(posedge clk_i) begin
    s2_neg_q <= dot_d[DW-1];
    for (int i = 0; i < 4; i++) begin
      s2_sum_q[i] <= s1_pa_q[i] + s1_pb_q[i];
      s2_dif_q[i] <= s1_pa_q[i] - s1_pb_q[i];
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: pick the blend, split into sign and magnitude
  // ---------------------------------------------------------------------
  logic signed [VW-1:0] v_d [4];
  logic                 s3_vld_q;
  logic [3:0]           s3_sgn_q;
  logic [MW-1:0]        s3_m_q [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      v_d[i] = s2_neg_q ? s2_dif_q[i] : s2_sum_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      s3_sgn_q[i] <= v_d[i][VW-1];
      s3_m_q[i]   <= v_d[i][VW-1] ? MW'(-v_d[i]) : MW'(v_d[i]);
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: bit length of the largest magnitude
  // ---------------------------------------------------------------------
  logic [MW-1:0] or_m;
  logic [EW-1:0] s4_e_d;

  assign or_m = s3_m_q[0] | s3_m_q[1] | s3_m_q[2] | s3_m_q[3];

  always_comb begin
    s4_e_d = '0;
    for (int i = 0; i < MW; i++) begin
      if (or_m[i]) s4_e_d = EW'(i + 1);
    end
  end

  side_t         s4_side_q;
  logic [EW-1:0] s4_e_q;
  logic [MW-1:0] s4_m_q [4];

  always_ff @(posedge clk_i) begin
    s4_e_q <= s4_e_d;
    s4_m_q <= s3_m_q;
  end

  // ---------------------------------------------------------------------
  // stage 5: align so the largest magnitude has its top bit at 2^29
  // ---------------------------------------------------------------------
  logic [SW-1:0] win_d [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      win_d[i] = {s4_m_q[i], {R_W{1'b0}}} >> s4_e_q;
    end
  end

  side_t          s5_side_q;
  logic [R_W-1:0] s5_r_q [4];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      s5_r_q[i] <= win_d[i][R_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // stage 6: squares
  // ---------------------------------------------------------------------
  side_t           s6_side_q;
  logic [SQ_W-1:0] s6_sq_q [4];
  logic [R_W-1:0]  s6_r_q [4];

  always_ff @(posedge clk_i) begin
    s6_r_q <= s5_r_q;
    for (int i = 0; i < 4; i++) begin
      s6_sq_q[i] <= SQ_W'(s5_r_q[i]) * SQ_W'(s5_r_q[i]);
    end
  end

  // ---------------------------------------------------------------------
  // square root: stage 0 holds the squared length, then one bit per stage
  // ---------------------------------------------------------------------
  logic [RM_W-1:0]   rt_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] rt_root_q [ROOT_W+1];
  logic [Q_W-1:0]    rt_val_q  [ROOT_W+1];
  logic [R_W-1:0]    rt_r_q    [ROOT_W+1][4];
  side_t             rt_side_q [ROOT_W+1];

  always_ff @(posedge clk_i) begin
    rt_rem_q[0]  <= '0;
    rt_root_q[0] <= '0;
    rt_val_q[0]  <= Q_W'(s6_sq_q[0]) + Q_W'(s6_sq_q[1])
                  + Q_W'(s6_sq_q[2]) + Q_W'(s6_sq_q[3]);
    rt_r_q[0]    <= s6_r_q;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int unsigned J = ROOT_W - 1 - k;
    logic [RM_W-1:0] rem_x;
    logic [RM_W-1:0] trial;
    logic            take;

    // bring down two bits, try the next root bit
    always_comb begin
      rem_x = {rt_rem_q[k][RM_W-3:0], rt_val_q[k][2*J+1 -: 2]};
      trial = RM_W'({rt_root_q[k], 2'b01});
      take  = (rem_x >= trial);
    end

    always_ff @(posedge clk_i) begin
      rt_rem_q[k+1]  <= take ? (rem_x - trial) : rem_x;
      rt_root_q[k+1] <= {rt_root_q[k][ROOT_W-2:0], take};
      rt_val_q[k+1]  <= rt_val_q[k];
      rt_r_q[k+1]    <= rt_r_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_side_q[k+1] <= '0;
      end else begin
        rt_side_q[k+1] <= rt_side_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // divider: stage 0 forms the rounded dividend, then one quotient bit
  // per stage, four lanes sharing the length
  // ---------------------------------------------------------------------
  logic [NW-1:0]     num_d [4];
  logic [ROOT_W-1:0] dv_rem_q  [QB+1][4];
  logic [QB-1:0]     dv_quo_q  [QB+1][4];
  logic [QB-1:0]     dv_low_q  [QB+1][4];
  logic [ROOT_W-1:0] dv_len_q  [QB+1];
  side_t             dv_side_q [QB+1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num_d[i] = (NW'(rt_r_q[ROOT_W][i]) << FB) + NW'(rt_root_q[ROOT_W] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    dv_len_q[0] <= rt_root_q[ROOT_W];
    for (int i = 0; i < 4; i++) begin
      dv_rem_q[0][i] <= ROOT_W'(num_d[i] >> QB);
      dv_low_q[0][i] <= num_d[i][QB-1:0];
      dv_quo_q[0][i] <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [ROOT_W:0] rem_x;
      logic            take;

      // shift in the next dividend bit, subtract the length if it fits
      always_comb begin
        rem_x = {dv_rem_q[k][i], dv_low_q[k][i][QB-1-k]};
        take  = (rem_x >= {1'b0, dv_len_q[k]});
      end

      always_ff @(posedge clk_i) begin
        dv_rem_q[k+1][i] <= take ? ROOT_W'(rem_x - {1'b0, dv_len_q[k]})
                                 : ROOT_W'(rem_x);
        dv_quo_q[k+1][i] <= {dv_quo_q[k][i][QB-2:0], take};
        dv_low_q[k+1][i] <= dv_low_q[k][i];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_len_q[k+1] <= dv_len_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_side_q[k+1] <= '0;
      end else begin
        dv_side_q[k+1] <= dv_side_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // output register: clamp to one, apply sign, zero-length override
  // ---------------------------------------------------------------------
  logic [QB-1:0]        mag_d [4];
  logic signed [CB-1:0] out_d [4];
  logic signed [CB-1:0] out_q [4];
  logic                 deg_q;
  logic                 done_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_d[i] = (dv_quo_q[QB][i] > MAG_ONE) ? MAG_ONE : dv_quo_q[QB][i];
      if (dv_side_q[QB].zero) begin
        out_d[i] = '0;
      end else if (dv_side_q[QB].neg[i]) begin
        out_d[i] = -CB'(mag_d[i]);
      end else begin
        out_d[i] = CB'(mag_d[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    deg_q <= dv_side_q[QB].zero;
  end

  // ---------------------------------------------------------------------
  // valid bits and sideband of the front half
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      s3_vld_q     <= 1'b0;
      s4_side_q    <= '0;
      s5_side_q    <= '0;
      s6_side_q    <= '0;
      rt_side_q[0] <= '0;
      dv_side_q[0] <= '0;
      done_q       <= 1'b0;
    end else begin
      s1_vld_q     <= start_i && !busy_o;
      s2_vld_q     <= s1_vld_q;
      s3_vld_q     <= s2_vld_q;
      s4_side_q    <= '{vld: s3_vld_q, zero: (or_m == '0), neg: s3_sgn_q};
      s5_side_q    <= s4_side_q;
      s6_side_q    <= s5_side_q;
      rt_side_q[0] <= s6_side_q;
      dv_side_q[0] <= rt_side_q[ROOT_W];
      done_q       <= dv_side_q[QB].vld;
    end
  end

  assign done_o       = done_q;
  assign out_x_o      = out_q[0];
  assign out_y_o      = out_q[1];
  assign out_z_o      = out_q[2];
  assign out_w_o      = out_q[3];
  assign degenerate_o = deg_q;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // alignment puts the largest component at the top bit
  a_align_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s5_side_q.vld && !s5_side_q.zero) |->
      ((s5_r_q[0] | s5_r_q[1] | s5_r_q[2] | s5_r_q[3]) >> (R_W - 1)) == R_W'(1))
    else $error("aligned magnitude not normalized");

  // a non-degenerate length is at least 2^29
  a_root_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rt_side_q[ROOT_W].vld && !rt_side_q[ROOT_W].zero) |->
      (rt_root_q[ROOT_W][ROOT_W-1 -: 2] != 2'b00))
    else $error("square root below range");

  // no component exceeds one before clamping
  a_quo_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_side_q[QB].vld && !dv_side_q[QB].zero) |->
      (dv_quo_q[QB][0] <= MAG_ONE && dv_quo_q[QB][1] <= MAG_ONE &&
       dv_quo_q[QB][2] <= MAG_ONE && dv_quo_q[QB][3] <= MAG_ONE))
    else $error("quotient above one");

  // zero-length results carry all-zero components
  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |->
      (out_x_o == '0 && out_y_o == '0 && out_z_o == '0 && out_w_o == '0))
    else $error("degenerate result with nonzero component");

  // a unit-length result cannot be all zero
  a_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !degenerate_o) |->
      (out_x_o != '0 || out_y_o != '0 || out_z_o != '0 || out_w_o != '0))
    else $error("normalized result is all zero");

endmodule

>>> bench/tb_top.sv
module tb_top
  import qnlerp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = 16;
  localparam int unsigned FB = CB - 2;
  localparam int LATENCY = CB + 38;
  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [CB-1:0] Q_ONE = CB'(1 <<< FB);
  localparam logic signed [CB-1:0] Q_NEG_ONE = CB'(-(1 <<< FB));
  localparam logic signed [CB-1:0] C_MAX = CB'((1 <<< (CB - 1)) - 1);
  localparam logic signed [CB-1:0] C_MIN = CB'(-(1 <<< (CB - 1)));
  localparam logic [BLEND_W-1:0] BLEND_HALF = BLEND_ONE >> 1;
  localparam logic [BLEND_W-1:0] BLEND_ALL = '1;

  typedef struct packed {
    logic signed [CB-1:0] fx;
    logic signed [CB-1:0] fy;
    logic signed [CB-1:0] fz;
    logic signed [CB-1:0] fw;
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic signed [CB-1:0] sz;
    logic signed [CB-1:0] sw;
    logic [BLEND_W-1:0]   blend;
  } blend_item_t;

  typedef struct packed {
    logic signed [CB-1:0] ox;
    logic signed [CB-1:0] oy;
    logic signed [CB-1:0] oz;
    logic signed [CB-1:0] ow;
    logic                 degen;
  } quat_result_t;

  typedef struct packed {
    blend_item_t  it;
    bit           typed;
    quat_result_t res;
  } stim_row_t;

  localparam quat_result_t RES_DEGEN = '{'0, '0, '0, '0, 1'b1};
  localparam quat_result_t RES_NONE  = '{'0, '0, '0, '0, 1'b0};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic signed [CB-1:0] first_x_i, first_y_i, first_z_i, first_w_i;
  logic signed [CB-1:0] second_x_i, second_y_i, second_z_i, second_w_i;
  logic [BLEND_W-1:0]   blend_i;
  logic                 done_o;
  logic signed [CB-1:0] out_x_o, out_y_o, out_z_o, out_w_o;
  logic                 degenerate_o;

  quat_result_t pending_results[$];
  stim_row_t    directed_rows[$];
  int           err_count = 0;
  int           cycle_cnt = 0;

  quaternion_nlerp #(.COMPONENT_BITS(CB)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .first_x_i    (first_x_i),
    .first_y_i    (first_y_i),
    .first_z_i    (first_z_i),
    .first_w_i    (first_w_i),
    .second_x_i   (second_x_i),
    .second_y_i   (second_y_i),
    .second_z_i   (second_z_i),
    .second_w_i   (second_w_i),
    .blend_i      (blend_i),
    .done_o       (done_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .out_w_o      (out_w_o),
    .degenerate_o (degenerate_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // exact blend, align, integer root and rounded divide
  function automatic quat_result_t nlerp_predict(input blend_item_t it);
    longint a[4], b[4], v[4];
    longint unsigned m[4], r[4];
    longint unsigned maxm, q, len, mag, w1, w0, rem, bitv;
    longint dot;
    logic [CB-1:0] outc[4];
    logic [CB-1:0] mg;
    int e;
    a[0] = longint'(it.fx); a[1] = longint'(it.fy);
    a[2] = longint'(it.fz); a[3] = longint'(it.fw);
    b[0] = longint'(it.sx); b[1] = longint'(it.sy);
    b[2] = longint'(it.sz); b[3] = longint'(it.sw);
    w1 = 64'((it.blend > BLEND_ONE) ? BLEND_ONE : it.blend);
    w0 = longint'(BLEND_ONE) - w1;
    dot = 0;
    for (int i = 0; i < 4; i++) dot += a[i] * b[i];
    maxm = 0;
    for (int i = 0; i < 4; i++) begin
      v[i] = a[i] * longint'(w0) +
             ((dot < 0) ? -(b[i] * longint'(w1)) : b[i] * longint'(w1));
      m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
      if (m[i] > maxm) maxm = m[i];
    end
    if (maxm == 0) return RES_DEGEN;
    e = 0;
    while (e < 64 && (maxm >> e) != 0) e++;
    q = 0;
    for (int i = 0; i < 4; i++) begin
      r[i] = (e > 30) ? (m[i] >> (e - 30)) : (m[i] << (30 - e));
      q += r[i] * r[i];
    end
    // bitwise integer square root
    len = 0;
    rem = q;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= len + bitv) begin
        rem -= len + bitv;
        len = (len >> 1) + bitv;
      end else begin
        len >>= 1;
      end
      bitv >>= 2;
    end
    for (int i = 0; i < 4; i++) begin
      mag = ((r[i] << FB) + (len >> 1)) / len;
      if (mag > (64'd1 << FB)) mag = 64'd1 << FB;
      mg = mag[CB-1:0];
      outc[i] = (v[i] < 0) ? -mg : mg;
    end
    return '{outc[0], outc[1], outc[2], outc[3], 1'b0};
  endfunction

  function automatic logic [CB-1:0] rand_comp(input int mode);
    logic [CB-1:0] c;
    case (mode)
      0: c = CB'($urandom);
      1: begin
        c = CB'($urandom_range(0, 1 << FB));
        if ($urandom_range(1)) c = -c;
      end
      2: c = $urandom_range(1) ? CB'($urandom) : '0;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic blend_item_t rand_item();
    blend_item_t it;
    int pick, fm, sm;
    pick = $urandom_range(99);
    fm = 0;
    sm = 0;
    if (pick < 55) begin
      fm = 0; sm = 0;
    end else if (pick < 75) begin
      fm = 1; sm = 1;
    end else if (pick < 88) begin
      fm = 2; sm = 2;
    end else if (pick < 94) begin
      fm = 3; sm = 0;
    end else begin
      fm = 0; sm = 3;
    end
    it.fx = rand_comp(fm); it.fy = rand_comp(fm);
    it.fz = rand_comp(fm); it.fw = rand_comp(fm);
    it.sx = rand_comp(sm); it.sy = rand_comp(sm);
    it.sz = rand_comp(sm); it.sw = rand_comp(sm);
    // second near first, with its z component negated
    if (pick >= 75 && pick < 80) begin
      it.sx = it.fx ^ CB'($urandom_range(3));
      it.sy = it.fy;
      it.sz = -it.fz;
      it.sw = it.fw;
    end
    pick = $urandom_range(99);
    if (pick < 70) it.blend = BLEND_W'($urandom_range(0, BLEND_ONE));
    else if (pick < 80) it.blend = BLEND_W'($urandom);
    else if (pick < 90) it.blend = $urandom_range(1) ? BLEND_ONE : '0;
    else it.blend = BLEND_W'($urandom_range(BLEND_ONE + 1, BLEND_ALL));
    return it;
  endfunction

  // present one item and wait until it is taken
  task automatic send_item(input stim_row_t row);
    start_i    <= 1'b1;
    first_x_i  <= row.it.fx;
    first_y_i  <= row.it.fy;
    first_z_i  <= row.it.fz;
    first_w_i  <= row.it.fw;
    second_x_i <= row.it.sx;
    second_y_i <= row.it.sy;
    second_z_i <= row.it.sz;
    second_w_i <= row.it.sw;
    blend_i    <= row.it.blend;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(row.typed ? row.res : nlerp_predict(row.it));
  endtask

  // random gap before an item, none inside the quiet stretch
  task automatic maybe_idle(input bit quiet);
    if (!quiet && $urandom_range(99) < 8) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // compare one field
  task automatic check_field(input string name, input logic [CB-1:0] exp_v,
                             input logic [CB-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name,
             $signed(exp_v), $signed(act_v));
      err_count++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    quat_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending");
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("out_x", exp_r.ox, out_x_o);
        check_field("out_y", exp_r.oy, out_y_o);
        check_field("out_z", exp_r.oz, out_z_o);
        check_field("out_w", exp_r.ow, out_w_o);
        if (exp_r.degen !== degenerate_o) begin
          $error("degenerate mismatch: expected %0d actual %0d",
                 exp_r.degen, degenerate_o);
          err_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t row;
    rst_ni     <= 1'b0;
    start_i    <= 1'b0;
    first_x_i  <= '0;
    first_y_i  <= '0;
    first_z_i  <= '0;
    first_w_i  <= '0;
    second_x_i <= '0;
    second_y_i <= '0;
    second_z_i <= '0;
    second_w_i <= '0;
    blend_i    <= '0;

    // all zero gives the degenerate flag
    directed_rows.push_back('{'{'0, '0, '0, '0, '0, '0, '0, '0, BLEND_HALF}, 1'b1,
                              RES_DEGEN});
    // weight zero returns first
    directed_rows.push_back('{'{Q_ONE, '0, '0, '0, Q_ONE, '0, '0, '0, '0}, 1'b1,
                              '{Q_ONE, '0, '0, '0, 1'b0}});
    directed_rows.push_back('{'{Q_NEG_ONE, '0, '0, '0, '0, '0, '0, '0, '0}, 1'b1,
                              '{Q_NEG_ONE, '0, '0, '0, 1'b0}});
    // weight one returns second
    directed_rows.push_back('{'{'0, '0, '0, '0, '0, '0, '0, Q_ONE, BLEND_ONE}, 1'b1,
                              '{'0, '0, '0, Q_ONE, 1'b0}});
    // weight above one clamps to one
    directed_rows.push_back('{'{'0, '0, '0, '0, '0, Q_ONE, '0, '0, BLEND_ALL}, 1'b1,
                              '{'0, Q_ONE, '0, '0, 1'b0}});
    // negative dot product flips second
    directed_rows.push_back('{'{Q_ONE, '0, '0, '0, Q_NEG_ONE, '0, '0, '0, BLEND_HALF},
                              1'b1, '{Q_ONE, '0, '0, '0, 1'b0}});
    // zero length with nonzero inputs
    directed_rows.push_back('{'{'0, '0, '0, '0, 16'sd1234, -16'sd5, 16'sd7, C_MAX, '0},
                              1'b1, RES_DEGEN});
    directed_rows.push_back('{'{Q_ONE, '0, '0, '0, '0, '0, '0, '0, BLEND_ONE}, 1'b1,
                              RES_DEGEN});
    // dot product exactly zero adds second
    directed_rows.push_back('{'{Q_ONE, '0, '0, '0, '0, Q_ONE, '0, '0, BLEND_HALF},
                              1'b0, RES_NONE});
    // component extremes
    directed_rows.push_back('{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN,
                              BLEND_HALF}, 1'b0, RES_NONE});
    directed_rows.push_back('{'{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                              BLEND_ONE}, 1'b0, RES_NONE});
    directed_rows.push_back('{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                              BLEND_ONE - 16'd1}, 1'b0, RES_NONE});
    directed_rows.push_back('{'{C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN,
                              16'd1}, 1'b0, RES_NONE});
    // tiny magnitudes need the left alignment
    directed_rows.push_back('{'{16'sd1, '0, '0, '0, '0, '0, '0, 16'sd1, 16'd1}, 1'b0,
                              RES_NONE});
    directed_rows.push_back('{'{16'sd1, -16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd1,
                              -16'sd1, 16'sd1, BLEND_ONE + 16'd1}, 1'b0, RES_NONE});
    // alternating bit patterns
    directed_rows.push_back('{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA,
                              16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, RES_NONE});
    directed_rows.push_back('{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                              16'h5555, 16'hAAAA, 16'h5555, 16'h5555}, 1'b0, RES_NONE});
    directed_rows.push_back('{'{Q_ONE, C_MIN, 16'sd1, '0, -16'sd1, C_MAX, Q_NEG_ONE,
                              16'sd5, 16'h1234}, 1'b0, RES_NONE});
    directed_rows.push_back('{'{16'sd1, '0, '0, '0, C_MIN, '0, '0, '0, BLEND_ONE}, 1'b0,
                              RES_NONE});

    // hold reset, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      maybe_idle(1'b0);
      send_item(directed_rows[i]);
    end

    // random items, a quiet stretch in the middle
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      maybe_idle(n >= 700 && n < 1100);
      row.it = rand_item();
      row.typed = 1'b0;
      row.res = RES_NONE;
      send_item(row);
    end
    start_i <= 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
